FILE: design/alcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alcd_pkg
// Shared types and constants of the addressable LED chain driver.
// ----------------------------------------------------------------------------
package alcd_pkg;

    localparam int MAX_LEDS = 64;
    localparam int IDX_W    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CNT_W    = $clog2(MAX_LEDS + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TICK_W     = 12;
    localparam int GAP_W      = 16;
    localparam int BITPOS_W   = 5;
    localparam int PIXEL_W    = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP       = 3'd4;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    localparam logic [BITPOS_W-1:0] TOP_BIT = 5'd23;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_WRITE,
        CMD_START,
        CMD_NOP
    } cmd_kind_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_GAP
    } phase_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic                   bad;
        logic [IDX_W-1:0]       idx;
        logic [PIXEL_W-1:0]     grb;
        logic [CNT_W-1:0]       cnt;
    } cmd_t;

endpackage

FILE: design/alcd_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alcd_req_if
// Request channel: tick, pixel write and start refresh items.
// ----------------------------------------------------------------------------
interface alcd_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [6:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] led_count;

    modport source (output valid, req_type, led_index, red, green, blue, led_count,
                    input ready);
    modport sink   (input valid, req_type, led_index, red, green, blue, led_count,
                    output ready);
endinterface

FILE: design/alcd_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alcd_res_if
// Result channel: line level and status flags, one per request.
// ----------------------------------------------------------------------------
interface alcd_res_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic done_res;
    logic rejected;

    modport source (output valid, line_level, busy_res, done_res, rejected,
                    input ready);
    modport sink   (input valid, line_level, busy_res, done_res, rejected,
                    output ready);
endinterface

FILE: design/alcd_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alcd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface alcd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/addressable_led_chain_driver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressable_led_chain_driver_top
// Single-wire addressable RGB LED chain driver with a 64-entry pixel store.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the command queue has room and
// returns one result per request, in order. A front decoder feeds a two-entry
// command queue, and the back sequencer retires one command per clock while
// the result side accepts, so request and result sides stall independently.
// The pixel store needs no clearing pass: per-entry valid bits make unwritten
// pixels read dark right after reset. Configuration writes are taken in every
// cycle and must only be issued while the chain is idle.
module addressable_led_chain_driver_top
    import alcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    alcd_req_if.sink    req,
    alcd_res_if.source  res,
    alcd_cfg_if.sink    cfg
);

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    alcd_front u_front
    (
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    alcd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    alcd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .cfg        (cfg),
        .res        (res)
    );

endmodule

FILE: design/alcd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alcd_front
// Accepts requests, decodes the kind and flags out-of-range index or count.
// ----------------------------------------------------------------------------
module alcd_front
    import alcd_pkg::*;
(
    alcd_req_if.sink req,
    output logic     push_valid,
    input  logic     push_ready,
    output cmd_t     push_cmd
);

    localparam int IDX_EXT_W = IDX_W + 7;

    logic [IDX_EXT_W-1:0] idx_m1;
    logic                 idx_bad;
    logic                 cnt_bad;

    assign req.ready  = push_ready;
    assign push_valid = req.valid;

    assign idx_m1  = IDX_EXT_W'(req.led_index) - IDX_EXT_W'(1);
    assign idx_bad = (req.led_index == 7'd0) || ({25'd0, req.led_index} > 32'(MAX_LEDS));
    assign cnt_bad = {25'd0, req.led_count} > 32'(MAX_LEDS);

    always_comb
    begin
        push_cmd.idx = idx_m1[IDX_W-1:0];
        push_cmd.grb = {req.green, req.red, req.blue};
        push_cmd.cnt = CNT_W'(req.led_count);
        case (req.req_type)
            REQ_TICK:
            begin
                push_cmd.kind = CMD_TICK;
                push_cmd.bad  = 1'b0;
            end
            REQ_WRITE:
            begin
                push_cmd.kind = CMD_WRITE;
                push_cmd.bad  = idx_bad;
            end
            REQ_START:
            begin
                push_cmd.kind = CMD_START;
                push_cmd.bad  = cnt_bad;
            end
            default:
            begin
                push_cmd.kind = CMD_NOP;
                push_cmd.bad  = 1'b0;
            end
        endcase
    end

endmodule

FILE: design/alcd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alcd_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module alcd_queue
    import alcd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wptr_reg;
    logic [PTR_W-1:0]  wptr_next;
    logic [PTR_W-1:0]  rptr_reg;
    logic [PTR_W-1:0]  rptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              push;
    logic              pop;

    assign push_ready = fill_reg != FILL_W'(QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_cmd    = slot_reg[rptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (push)
        begin
            wptr_next = (32'(wptr_reg) == QUEUE_DEPTH - 1) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rptr_next = (32'(rptr_reg) == QUEUE_DEPTH - 1) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: design/alcd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alcd_back
// Pixel store, bit timing sequencer, configuration registers and result
// register.
// ----------------------------------------------------------------------------
module alcd_back
    import alcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  cmd_t      pop_cmd,
    alcd_cfg_if.sink  cfg,
    alcd_res_if.source res
);

    logic [PIXEL_W-1:0]  pix_mem [MAX_LEDS];
    logic [MAX_LEDS-1:0] pix_valid_reg;
    logic [PIXEL_W-1:0]  pix0_reg;
    logic [PIXEL_W-1:0]  next_word_reg;

    logic [TICK_W-1:0]   zero_high_reg;
    logic [TICK_W-1:0]   zero_low_reg;
    logic [TICK_W-1:0]   one_high_reg;
    logic [TICK_W-1:0]   one_low_reg;
    logic [GAP_W-1:0]    gap_reg;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [GAP_W-1:0]    counter_reg;
    logic [GAP_W-1:0]    counter_next;
    logic [BITPOS_W-1:0] bitpos_reg;
    logic [BITPOS_W-1:0] bitpos_next;
    logic [IDX_W-1:0]    ptr_reg;
    logic [IDX_W-1:0]    ptr_next;
    logic [CNT_W-1:0]    leds_reg;
    logic [CNT_W-1:0]    leds_next;
    logic [PIXEL_W-1:0]  shift_reg;
    logic [PIXEL_W-1:0]  shift_next;
    logic                line_reg;
    logic                line_next;

    logic                res_valid_reg;
    logic                res_line_reg;
    logic                res_busy_reg;
    logic                res_done_reg;
    logic                res_rej_reg;

    logic                fire;
    logic                busy;
    logic [GAP_W-1:0]    counter_dec;
    logic                cur_bit;
    logic                wr_en;
    logic                load_led;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [CNT_W:0]      rd_sum;
    logic [CNT_W:0]      ptr_inc;
    logic                done_flag;
    logic                rej_flag;

    function automatic logic [GAP_W-1:0] at_least_one(input logic [GAP_W-1:0] v);
        return (v == '0) ? GAP_W'(1) : v;
    endfunction

    function automatic logic [GAP_W-1:0] high_ticks(input logic b,
                                                    input logic [TICK_W-1:0] t1,
                                                    input logic [TICK_W-1:0] t0);
        return at_least_one(GAP_W'(b ? t1 : t0));
    endfunction

    assign cfg.ready   = 1'b1;
    assign pop_ready   = !res_valid_reg || res.ready;
    assign fire        = pop_valid && pop_ready;
    assign busy        = phase_reg != PH_IDLE;
    assign counter_dec = counter_reg - GAP_W'(1);
    assign cur_bit     = shift_reg[bitpos_reg];
    assign ptr_inc     = (CNT_W + 1)'(ptr_reg) + (CNT_W + 1)'(1);

    assign res.valid      = res_valid_reg;
    assign res.line_level = res_line_reg;
    assign res.busy_res   = res_busy_reg;
    assign res.done_res   = res_done_reg;
    assign res.rejected   = res_rej_reg;

    // Next state
    always_comb
    begin
        phase_next   = phase_reg;
        counter_next = counter_reg;
        bitpos_next  = bitpos_reg;
        ptr_next     = ptr_reg;
        leds_next    = leds_reg;
        shift_next   = shift_reg;
        line_next    = line_reg;
        wr_en        = 1'b0;
        load_led     = 1'b0;
        if (fire)
        begin
            case (pop_cmd.kind)
                CMD_WRITE:
                begin
                    wr_en = !busy && !pop_cmd.bad;
                end
                CMD_START:
                begin
                    if (!busy && !pop_cmd.bad)
                    begin
                        leds_next = pop_cmd.cnt;
                        ptr_next  = '0;
                        if (pop_cmd.cnt == '0)
                        begin
                            phase_next   = PH_GAP;
                            line_next    = 1'b0;
                            counter_next = at_least_one(gap_reg);
                        end
                        else
                        begin
                            load_led     = 1'b1;
                            shift_next   = pix0_reg;
                            bitpos_next  = TOP_BIT;
                            phase_next   = PH_HIGH;
                            line_next    = 1'b1;
                            counter_next = high_ticks(pix0_reg[TOP_BIT], one_high_reg,
                                                      zero_high_reg);
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (busy)
                    begin
                        counter_next = counter_dec;
                        if (counter_dec == '0)
                        begin
                            case (phase_reg)
                                PH_HIGH:
                                begin
                                    phase_next   = PH_LOW;
                                    line_next    = 1'b0;
                                    counter_next = high_ticks(cur_bit, one_low_reg,
                                                              zero_low_reg);
                                end
                                PH_LOW:
                                begin
                                    if (bitpos_reg != '0)
                                    begin
                                        bitpos_next  = bitpos_reg - BITPOS_W'(1);
                                        phase_next   = PH_HIGH;
                                        line_next    = 1'b1;
                                        counter_next = high_ticks(shift_reg[bitpos_next],
                                                                  one_high_reg,
                                                                  zero_high_reg);
                                    end
                                    else if (ptr_inc < (CNT_W + 1)'(leds_reg))
                                    begin
                                        load_led     = 1'b1;
                                        ptr_next     = ptr_inc[IDX_W-1:0];
                                        shift_next   = next_word_reg;
                                        bitpos_next  = TOP_BIT;
                                        phase_next   = PH_HIGH;
                                        line_next    = 1'b1;
                                        counter_next = high_ticks(next_word_reg[TOP_BIT],
                                                                  one_high_reg,
                                                                  zero_high_reg);
                                    end
                                    else
                                    begin
                                        phase_next   = PH_GAP;
                                        line_next    = 1'b0;
                                        counter_next = at_least_one(gap_reg);
                                    end
                                end
                                PH_GAP:
                                begin
                                    phase_next = PH_IDLE;
                                    line_next  = 1'b0;
                                end
                                default:
                                begin
                                    phase_next = PH_IDLE;
                                end
                            endcase
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Prefetch the LED after the one being loaded
    assign rd_sum  = (CNT_W + 1)'(ptr_next) + (CNT_W + 1)'(1);
    assign rd_en   = load_led && (32'(rd_sum) < MAX_LEDS);
    assign rd_addr = rd_sum[IDX_W-1:0];

    // Outputs
    always_comb
    begin
        done_flag = 1'b0;
        rej_flag  = 1'b0;
        case (pop_cmd.kind)
            CMD_TICK:
            begin
                done_flag = busy && (phase_reg == PH_GAP) && (counter_dec == '0);
            end
            CMD_WRITE, CMD_START:
            begin
                rej_flag = busy || pop_cmd.bad;
            end
            default:
            begin
                done_flag = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            counter_reg   <= '0;
            bitpos_reg    <= '0;
            ptr_reg       <= '0;
            leds_reg      <= '0;
            shift_reg     <= '0;
            line_reg      <= 1'b0;
            pix_valid_reg <= '0;
            pix0_reg      <= '0;
            res_valid_reg <= 1'b0;
            zero_high_reg <= 12'd20;
            zero_low_reg  <= 12'd43;
            one_high_reg  <= 12'd43;
            one_low_reg   <= 12'd20;
            gap_reg       <= 16'd3300;
        end
        else
        begin
            phase_reg   <= phase_next;
            counter_reg <= counter_next;
            bitpos_reg  <= bitpos_next;
            ptr_reg     <= ptr_next;
            leds_reg    <= leds_next;
            shift_reg   <= shift_next;
            line_reg    <= line_next;
            if (wr_en)
            begin
                pix_valid_reg[pop_cmd.idx] <= 1'b1;
                if (pop_cmd.idx == '0)
                begin
                    pix0_reg <= pop_cmd.grb;
                end
            end
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_ZERO_HIGH: zero_high_reg <= cfg.data[TICK_W-1:0];
                    CFG_ZERO_LOW:  zero_low_reg  <= cfg.data[TICK_W-1:0];
                    CFG_ONE_HIGH:  one_high_reg  <= cfg.data[TICK_W-1:0];
                    CFG_ONE_LOW:   one_low_reg   <= cfg.data[TICK_W-1:0];
                    CFG_GAP:       gap_reg       <= cfg.data[GAP_W-1:0];
                    default:       gap_reg       <= gap_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pix_mem[pop_cmd.idx] <= pop_cmd.grb;
        end
        if (rd_en)
        begin
            next_word_reg <= pix_valid_reg[rd_addr] ? pix_mem[rd_addr] : '0;
        end
        if (fire)
        begin
            res_line_reg <= line_next;
            res_busy_reg <= phase_next != PH_IDLE;
            res_done_reg <= done_flag;
            res_rej_reg  <= rej_flag;
        end
    end

endmodule
